### hdl/merged_texture_cache_tags_core_assert.svh
// Assertion macros shared by the cache tag store.
// Every macro samples on the rising edge of clk and is muted while rst is high.
`ifndef MERGED_TEXTURE_CACHE_TAGS_CORE_ASSERT_SVH
`define MERGED_TEXTURE_CACHE_TAGS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mtct_pkg.sv
package mtct_pkg;

  localparam int ENTRIES_DEF      = 64;
  localparam int TEXTURE_BITS_DEF = 12;

  localparam int TEX_W   = 12;
  localparam int ORIENT_W = 2;
  localparam int FRAME_W = 31;
  localparam int SLOT_W  = 6;
  localparam int CFG_W   = 7;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic                op;
    logic [TEX_W-1:0]    bottom_texture;
    logic [TEX_W-1:0]    top_texture;
    logic [ORIENT_W-1:0] orientation;
    logic [FRAME_W-1:0]  frame_number;
  } item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              must_free_old;
  } result_t;

endpackage

### hdl/mtct_ram.sv
module mtct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/mtct_ctrl.sv
module mtct_ctrl
  import mtct_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(ENTRIES+1)-1:0] active_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  item_t                        in_item,
  output logic                         res_valid,
  input  logic                         res_ready,
  output result_t                      res
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int KT_W   = (TEXTURE_BITS < TEX_W) ? TEXTURE_BITS : TEX_W;
  localparam int TAG_W  = 2 * KT_W + ORIENT_W;
  localparam int RANK_W = FRAME_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;

  item_t              item;
  logic [CNT_W-1:0]   issue_cnt;
  logic               chk_valid;
  logic [IDX_W-1:0]   chk_idx;
  logic [IDX_W-1:0]   victim;
  logic [RANK_W-1:0]  low_rank;
  logic [IDX_W-1:0]   wr_idx;
  logic               hit_r;
  logic [ENTRIES-1:0] stamp_valid;
  logic [ENTRIES-1:0] alloc;

  logic               issue;
  logic [TAG_W-1:0]   key;
  logic [TAG_W-1:0]   tag_rdata;
  logic [FRAME_W-1:0] stamp_rdata;
  logic [RANK_W-1:0]  cur_rank;
  logic               match;
  logic               better;
  logic               last;
  logic               tag_we;
  logic               stamp_we;

  assign issue    = (state == S_SCAN) && (issue_cnt < active_n);
  assign key      = {item.orientation, item.top_texture[KT_W-1:0],
                     item.bottom_texture[KT_W-1:0]};
  // Empty entries rank below every stamped entry.
  assign cur_rank = stamp_valid[chk_idx] ? {1'b1, stamp_rdata} : '0;
  assign match    = stamp_valid[chk_idx] && alloc[chk_idx] && (tag_rdata == key);
  assign better   = (chk_idx == '0) || (cur_rank < low_rank);
  assign last     = (CNT_W'(chk_idx) + CNT_W'(1)) == active_n;

  assign tag_we   = (state == S_WRITE) && !hit_r;
  assign stamp_we = (state == S_WRITE);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // Tags of flushed entries are never looked at again before a refill, so
  // a flush only drops the stamp valid bits.
  mtct_ram #(
    .WIDTH (TAG_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (wr_idx),
    .wdata (key),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (tag_rdata)
  );

  mtct_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (wr_idx),
    .wdata (item.frame_number),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (stamp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chk_valid   <= 1'b0;
      stamp_valid <= '0;
      alloc       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          chk_valid <= 1'b0;
          if (in_valid) begin
            item      <= in_item;
            issue_cnt <= '0;
            if (in_item.op == OP_FLUSH) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (i < int'(active_n)) begin
                  stamp_valid[i] <= 1'b0;
                end
              end
              res   <= '0;
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= issue;
          chk_idx   <= issue_cnt[IDX_W-1:0];
          if (issue) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          if (chk_valid) begin
            if (match) begin
              wr_idx <= chk_idx;
              hit_r  <= 1'b1;
              state  <= S_WRITE;
            end else begin
              if (better) begin
                low_rank <= cur_rank;
                victim   <= chk_idx;
              end
              if (last) begin
                wr_idx <= better ? chk_idx : victim;
                hit_r  <= 1'b0;
                state  <= S_WRITE;
              end
            end
          end
        end
        S_WRITE: begin
          res.hit           <= hit_r;
          res.slot          <= SLOT_W'(wr_idx);
          res.must_free_old <= !hit_r && alloc[wr_idx];
          if (!hit_r) begin
            stamp_valid[wr_idx] <= 1'b1;
            alloc[wr_idx]       <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/merged_texture_cache_tags_core.sv
// Lookup: the tag and stamp memories are read one entry per cycle, n = active entries;
// a hit ends the scan at the matching entry, while a miss scans all n entries.
// Flush: clears the stamp valid bits of the active entries. One item is in work at a
// time, so a new item is taken only once the last result has gone to the output register.
// Reset empties every entry and clears allocation; the count of active
// entries returns to ENTRIES.
module merged_texture_cache_tags_core
  import mtct_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // bottom_texture[11:0], top_texture[23:12], orientation[25:24],
  // frame_number[56:26], zero fill[63:57]
  input  logic [63:0]      s_axis_tdata,
  // operation[0]
  input  logic [0:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // slot[5:0], must_free_old[6], zero fill[7]
  output logic [7:0]       m_axis_tdata,
  // hit[0]
  output logic [0:0]       m_axis_tuser
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  `include "merged_texture_cache_tags_core_assert.svh"

  logic [CNT_W-1:0] active_n;
  item_t            in_item;
  result_t          res;
  result_t          out_res;
  logic             res_valid;
  logic             res_ready;

  assign in_item.op             = s_axis_tuser[0];
  assign in_item.bottom_texture = s_axis_tdata[11:0];
  assign in_item.top_texture    = s_axis_tdata[23:12];
  assign in_item.orientation    = s_axis_tdata[25:24];
  assign in_item.frame_number   = s_axis_tdata[56:26];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_n <= CNT_W'(ENTRIES);
    end else if (cfg_we) begin
      if (cfg_data == '0 || 32'(cfg_data) > 32'(ENTRIES)) begin
        active_n <= CNT_W'(ENTRIES);
      end else begin
        active_n <= CNT_W'(cfg_data);
      end
    end
  end

  mtct_ctrl #(
    .ENTRIES      (ENTRIES),
    .TEXTURE_BITS (TEXTURE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .active_n  (active_n),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register frees the controller as soon as its result is held.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_res.must_free_old, out_res.slot};
  assign m_axis_tuser = out_res.hit;

  `MTCT_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "input taken while an item is still in work")

  `MTCT_ASSERT_NOW(a_active_in_range, 1'b1,
    active_n != '0 && 32'(active_n) <= 32'(ENTRIES),
    "active entry count out of range")

endmodule
